[rtl/mpq_pkg.sv]
// Shared types, constants and pointer helpers for the multi-policy ready queue.
package mpq_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int TIME_BITS   = 16;
   localparam int ID_BITS     = 7;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TIME_BITS-1:0] DEFAULT_QUANTUM = TIME_BITS'(500);

   typedef enum logic [1:0] {
      POL_FIFO = 2'd0,
      POL_RR   = 2'd1,
      POL_SJF  = 2'd2,
      POL_PSJF = 2'd3
   } policy_type;

   typedef enum logic {
      MODE_INSERT   = 1'b0,
      MODE_DISPATCH = 1'b1
   } mode_type;

   typedef enum logic {
      CSR_POLICY  = 1'b0,
      CSR_QUANTUM = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RR_CMP,
      ST_RR_SWAP,
      ST_SJF_CMP,
      ST_SJF_PLACE,
      ST_DSP_EXE,
      ST_FINISH
   } state_type;

   // one queue entry, id in the lowest bits
   typedef struct packed {
      logic [TIME_BITS-1:0] remaining;
      logic [TIME_BITS-1:0] arrival;
      logic [ID_BITS-1:0]   id;
   } entry_type;

   localparam int ENTRY_W    = $bits(entry_type);
   localparam int REQ_DATA_W = ((ENTRY_W + 7) / 8) * 8;

   // one result word, served_id in the lowest bits
   typedef struct packed {
      logic [CNT_W-1:0]     occupancy;
      logic                 overflow;
      logic                 was_empty;
      logic                 task_done;
      logic [TIME_BITS-1:0] grant_length;
      logic [ID_BITS-1:0]   served_id;
   } rsp_type;

   localparam int RSP_W      = $bits(rsp_type);
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      entry_type        data;
   } mem_wr_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] diff;
      logic                 borrow;
      logic                 equal;
   } alu_res_type;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = PTR_W'(p + PTR_W'(1));
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == '0) r = PTR_W'(QUEUE_DEPTH - 1);
      else r = PTR_W'(p - PTR_W'(1));
      return r;
   endfunction

   // physical slot of a logical position, position never above the depth
   function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] c);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(p) + (CNT_W+1)'(c);
      if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
      return sum[PTR_W-1:0];
   endfunction

endpackage

[rtl/multi_policy_ready_queue_core.sv]
// Top level of the multi-policy ready queue: config registers, result register, sequencer.
// Steps from accepted word to result word: FIFO or empty-queue inserts, overflow and empty
// dispatch pass decode and finish; dispatch adds the execute state, round robin inserts the
// compare state and a swapped one the swap state too; sorted inserts repeat the compare state,
// which shifts one entry per cycle. A new word is taken only once the last one has finished.
// Reset (synchronous): queue empty, policy FIFO, quantum 500; entries are not cleared.
module multi_policy_ready_queue_core
   import mpq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // task_id, arrival_time, run_time, zero pad
   input  logic                  req_tuser,  // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // served_id, grant_length, task_done, was_empty,
                                             // overflow, occupancy, zero pad
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [TIME_BITS-1:0]  csr_wdata
);

   policy_type           policy_ff, policy_in;
   logic [TIME_BITS-1:0] quantum_ff, quantum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 res_valid;
   logic                 res_ready;
   rsp_type              res;
   mem_wr_type           mem_wr;
   logic [PTR_W-1:0]     mem_rd_addr;
   entry_type            mem_rd_data;
   logic [TIME_BITS-1:0] alu_a;
   logic [TIME_BITS-1:0] alu_b;
   alu_res_type          alu_res;

   // config register writes
   always_comb begin
      policy_in  = policy_ff;
      quantum_in = quantum_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_POLICY:  policy_in  = policy_type'(csr_wdata[1:0]);
            CSR_QUANTUM: quantum_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // hold a finished word until the sink takes it
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POL_FIFO;
         quantum_ff   <= DEFAULT_QUANTUM;
         rsp_valid_ff <= 1'b0;
      end else begin
         policy_ff    <= policy_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

   mpq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_tvalid),
      .item_ready  (req_tready),
      .item_mode   (mode_type'(req_tuser)),
      .item_entry  (entry_type'(req_tdata[ENTRY_W-1:0])),
      .policy      (policy_ff),
      .quantum     (quantum_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr      (mem_wr),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .alu_a       (alu_a),
      .alu_b       (alu_b),
      .alu_res     (alu_res)
   );

   mpq_store u_store (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   mpq_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .res  (alu_res)
   );

endmodule

[rtl/mpq_store.sv]
// Entry memory of the ready queue: one write port, one registered read port.
module mpq_store
   import mpq_pkg::*;
(
   input  logic             clock,
   input  mem_wr_type       wr,
   input  logic [PTR_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   // write one entry
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read one entry every cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mpq_alu.sv]
// Shared subtract and compare unit for all time comparisons of the queue.
module mpq_alu
   import mpq_pkg::*;
(
   input  logic [TIME_BITS-1:0] op_a,
   input  logic [TIME_BITS-1:0] op_b,
   output alu_res_type          res
);

   logic [TIME_BITS:0] wide_diff;

   // subtract with borrow out
   assign wide_diff  = {1'b0, op_a} - {1'b0, op_b};
   assign res.diff   = wide_diff[TIME_BITS-1:0];
   assign res.borrow = wide_diff[TIME_BITS];
   assign res.equal  = (wide_diff[TIME_BITS-1:0] == '0);

endmodule

[rtl/mpq_ctrl.sv]
// Sequencer of the ready queue: head and count, insert, sorted shift and dispatch steps.
module mpq_ctrl
   import mpq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  mode_type             item_mode,
   input  entry_type            item_entry,
   input  policy_type           policy,
   input  logic [TIME_BITS-1:0] quantum,
   output logic                 res_valid,
   input  logic                 res_ready,
   output rsp_type              res,
   output mem_wr_type           mem_wr,
   output logic [PTR_W-1:0]     mem_rd_addr,
   input  entry_type            mem_rd_data,
   output logic [TIME_BITS-1:0] alu_a,
   output logic [TIME_BITS-1:0] alu_b,
   input  alu_res_type          alu_res
);

   state_type        state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   mode_type         mode_ff, mode_in;
   entry_type        item_ff, item_in;
   rsp_type          result_ff, result_in;

   logic [PTR_W-1:0] tail;
   logic [PTR_W-1:0] slot_prev;
   logic             full;
   entry_type        rot_entry;

   assign tail      = ptr_add(head_ff, count_ff);
   assign slot_prev = ptr_dec(slot_ff);
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      steps_ff  <= steps_in;
      mode_ff   <= mode_in;
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   // next state, memory and unit controls
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      slot_in     = slot_ff;
      steps_in    = steps_ff;
      mode_in     = mode_ff;
      item_in     = item_ff;
      result_in   = result_ff;
      mem_wr      = '0;
      mem_rd_addr = head_ff;
      alu_a       = mem_rd_data.remaining;
      alu_b       = TIME_BITS'(1);
      item_ready  = 1'b0;
      res_valid   = 1'b0;
      rot_entry   = mem_rd_data;

      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               mode_in  = item_mode;
               item_in  = item_entry;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            result_in = '0;
            if (mode_ff == MODE_INSERT) begin
               if (full) begin
                  result_in.overflow = 1'b1;
                  state_in           = ST_FINISH;
               end else if (policy == POL_FIFO || count_ff == '0) begin
                  // append at the tail
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = tail;
                  mem_wr.data = item_ff;
                  count_in    = CNT_W'(count_ff + CNT_W'(1));
                  state_in    = ST_FINISH;
               end else begin
                  // fetch the entry ahead of the new tail
                  mem_rd_addr = ptr_dec(tail);
                  slot_in     = tail;
                  steps_in    = count_ff;
                  count_in    = CNT_W'(count_ff + CNT_W'(1));
                  state_in    = (policy == POL_RR) ? ST_RR_CMP : ST_SJF_CMP;
               end
            end else begin
               if (count_ff == '0) begin
                  result_in.was_empty = 1'b1;
                  state_in            = ST_FINISH;
               end else begin
                  mem_rd_addr = head_ff;
                  state_in    = ST_DSP_EXE;
               end
            end
         end

         ST_RR_CMP: begin
            alu_a       = item_ff.arrival;
            alu_b       = mem_rd_data.arrival;
            mem_wr.en   = 1'b1;
            mem_wr.addr = slot_ff;
            if (alu_res.equal) begin
               mem_wr.data = item_ff;
               state_in    = ST_FINISH;
            end else begin
               // swap: old tail moves back, new task goes ahead of it
               mem_wr.data = mem_rd_data;
               slot_in     = slot_prev;
               state_in    = ST_RR_SWAP;
            end
         end

         ST_RR_SWAP, ST_SJF_PLACE: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = slot_ff;
            mem_wr.data = item_ff;
            state_in    = ST_FINISH;
         end

         ST_SJF_CMP: begin
            alu_a       = item_ff.remaining;
            alu_b       = mem_rd_data.remaining;
            mem_wr.en   = 1'b1;
            mem_wr.addr = slot_ff;
            if (alu_res.borrow) begin
               // shift the longer entry back one slot, fetch the next one
               mem_wr.data = mem_rd_data;
               slot_in     = slot_prev;
               steps_in    = CNT_W'(steps_ff - CNT_W'(1));
               mem_rd_addr = ptr_dec(slot_prev);
               if (steps_ff == CNT_W'(1)) begin
                  state_in = ST_SJF_PLACE;
               end
            end else begin
               mem_wr.data = item_ff;
               state_in    = ST_FINISH;
            end
         end

         ST_DSP_EXE: begin
            alu_a                = mem_rd_data.remaining;
            alu_b                = (policy == POL_RR) ? quantum : TIME_BITS'(1);
            rot_entry.remaining  = alu_res.diff;
            result_in.served_id  = mem_rd_data.id;
            result_in.grant_length = mem_rd_data.remaining;
            result_in.task_done  = 1'b1;
            state_in             = ST_FINISH;
            case (policy)
               POL_RR: begin
                  if (!alu_res.borrow && !alu_res.equal) begin
                     // rotate the reduced head to the tail
                     result_in.grant_length = quantum;
                     result_in.task_done    = 1'b0;
                     mem_wr.en              = 1'b1;
                     mem_wr.addr            = tail;
                     mem_wr.data            = rot_entry;
                     head_in                = ptr_inc(head_ff);
                  end else begin
                     head_in  = ptr_inc(head_ff);
                     count_in = CNT_W'(count_ff - CNT_W'(1));
                  end
               end
               POL_PSJF: begin
                  if (!alu_res.borrow && !alu_res.equal) begin
                     // run one unit, keep the head in place
                     result_in.grant_length = TIME_BITS'(1);
                     result_in.task_done    = 1'b0;
                     mem_wr.en              = 1'b1;
                     mem_wr.addr            = head_ff;
                     mem_wr.data            = rot_entry;
                  end else begin
                     head_in  = ptr_inc(head_ff);
                     count_in = CNT_W'(count_ff - CNT_W'(1));
                  end
               end
               default: begin
                  head_in  = ptr_inc(head_ff);
                  count_in = CNT_W'(count_ff - CNT_W'(1));
               end
            endcase
         end

         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result word with the final count
   always_comb begin
      res           = result_ff;
      res.occupancy = count_ff;
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item_ready) |=> !item_ready)
      else $error("second word taken while one is in work");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(count_ff))
      else $error("count moved while idle");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.overflow) |-> (count_ff == CNT_W'(QUEUE_DEPTH)))
      else $error("overflow reported on a queue that is not full");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_wr.en |-> (state_ff != ST_IDLE && state_ff != ST_FINISH))
      else $error("memory written outside an item");
`endif

endmodule
